### rtl/core/plsg_pkg.sv
// Shared widths, constants and types of the piecewise-linear gray stretch unit.
package plsg_pkg;

    localparam int LEVEL_W   = 8;
    localparam int CFG_IDX_W = 8;
    localparam int LUT_DEPTH = 256;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
    localparam int DIV_STEPS = LEVEL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef logic [LEVEL_W-1:0] level_t;

    localparam level_t MAX_LEVEL = level_t'(LUT_DEPTH - 1);

    localparam logic [CFG_IDX_W-1:0] REG_P1_IN  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_P1_OUT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_P2_IN  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_P2_OUT = CFG_IDX_W'(3);

    typedef struct packed {
        logic   we;
        level_t addr;
        level_t data;
    } lut_wr_t;

    typedef struct packed {
        level_t quo;
        level_t rem;
    } div_res_t;

endpackage

### rtl/core/piecewise_linear_gray_stretch_unit.sv
// Top level of the piecewise-linear gray stretch unit: registers, table rebuild and stream.
//
// Pixels enter on in_valid/in_ready with pixel_in and leave on out_valid/out_ready with
// pixel_out, one result beat for every input beat, in order. Each pixel is looked up in a
// 256-entry mapping table held in a synchronous memory, so the stream runs at one pixel per
// clock while the queue has room; a result is registered, then queued and offered.
// A four-entry output queue decouples the sides: while the receiver stalls, the block keeps
// taking pixels until the queue and the memory read stage hold four results, then drops
// in_ready until the receiver takes a beat.
// The four breakpoint registers are written on cfg_we with cfg_index and cfg_data; an index
// beyond the list changes no register but still rebuilds the table.
// After reset and after every register write the table is rebuilt while in_ready is low:
// three serial dividers work out the slope of each segment, then a sweep writes all 256
// table entries, one entry per cycle. Reset loads the identity mapping into the registers
// and starts that rebuild.
module piecewise_linear_gray_stretch_unit
    import plsg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [LEVEL_W-1:0]   pixel_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [LEVEL_W-1:0]   pixel_out
);

    typedef enum logic [2:0] {
        ST_DIV  = 3'b001,
        ST_FILL = 3'b010,
        ST_RUN  = 3'b100
    } fill_state_t;

    fill_state_t state_reg;
    logic        start_reg;
    level_t      fill_cnt_reg;
    level_t      p1_in_reg;
    level_t      p1_out_reg;
    level_t      p2_in_reg;
    level_t      p2_out_reg;

    logic        rising;
    level_t      rise2;
    level_t      span2;
    level_t      rise3;
    level_t      span3;
    logic [2:0]  div_busy;
    div_res_t    step1;
    div_res_t    step2;
    div_res_t    step3;
    level_t      q1;
    level_t      q2;
    level_t      q3;
    logic        filling;
    logic        ramp_clear;
    level_t      entry;
    lut_wr_t     lut_wr;
    logic        lut_room;
    logic        rd_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_in_reg  <= '0;
            p1_out_reg <= '0;
            p2_in_reg  <= MAX_LEVEL;
            p2_out_reg <= MAX_LEVEL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_P1_IN:  p1_in_reg  <= cfg_data;
                REG_P1_OUT: p1_out_reg <= cfg_data;
                REG_P2_IN:  p2_in_reg  <= cfg_data;
                REG_P2_OUT: p2_out_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_DIV;
            start_reg    <= 1'b1;
            fill_cnt_reg <= '0;
        end
        else
        begin
            start_reg <= cfg_we;
            if (cfg_we)
            begin
                state_reg <= ST_DIV;
            end
            else
            begin
                case (state_reg)
                    ST_DIV:
                    begin
                        if (!start_reg && (div_busy == '0))
                        begin
                            state_reg    <= ST_FILL;
                            fill_cnt_reg <= '0;
                        end
                    end
                    ST_FILL:
                    begin
                        fill_cnt_reg <= fill_cnt_reg + 1'b1;
                        if (fill_cnt_reg == MAX_LEVEL)
                        begin
                            state_reg <= ST_RUN;
                        end
                    end
                    ST_RUN: ;
                    default: state_reg <= ST_DIV;
                endcase
            end
        end
    end

    assign rising = p2_out_reg >= p1_out_reg;
    assign rise2  = rising ? (p2_out_reg - p1_out_reg) : (p1_out_reg - p2_out_reg);
    assign span2  = p2_in_reg - p1_in_reg;
    assign rise3  = MAX_LEVEL - p2_out_reg;
    assign span3  = MAX_LEVEL - p2_in_reg;

    plsg_div u_div1 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .num   (p1_out_reg),
        .den   (p1_in_reg),
        .busy  (div_busy[0]),
        .res   (step1)
    );

    plsg_div u_div2 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .num   (rise2),
        .den   (span2),
        .busy  (div_busy[1]),
        .res   (step2)
    );

    plsg_div u_div3 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .num   (rise3),
        .den   (span3),
        .busy  (div_busy[2]),
        .res   (step3)
    );

    assign filling    = state_reg == ST_FILL;
    assign ramp_clear = state_reg == ST_DIV;

    // Each segment's line starts at its left breakpoint and steps once per table entry.
    plsg_ramp u_ramp1 (
        .clk     (clk),
        .clear   (ramp_clear),
        .advance (filling),
        .step    (step1),
        .span    (p1_in_reg),
        .level   (q1)
    );

    plsg_ramp u_ramp2 (
        .clk     (clk),
        .clear   (ramp_clear),
        .advance (filling && (fill_cnt_reg >= p1_in_reg)),
        .step    (step2),
        .span    (span2),
        .level   (q2)
    );

    plsg_ramp u_ramp3 (
        .clk     (clk),
        .clear   (ramp_clear),
        .advance (filling && (fill_cnt_reg >= p2_in_reg)),
        .step    (step3),
        .span    (span3),
        .level   (q3)
    );

    always_comb
    begin
        if (fill_cnt_reg <= p1_in_reg)
        begin
            entry = q1;
        end
        else if (fill_cnt_reg <= p2_in_reg)
        begin
            entry = rising ? (p1_out_reg + q2) : (p1_out_reg - q2);
        end
        else
        begin
            entry = p2_out_reg + q3;
        end
    end

    assign lut_wr.we   = filling;
    assign lut_wr.addr = fill_cnt_reg;
    assign lut_wr.data = entry;

    assign in_ready = (state_reg == ST_RUN) && lut_room;
    assign rd_en    = in_valid && in_ready;

    plsg_lut u_lut (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (lut_wr),
        .rd_en     (rd_en),
        .rd_addr   (pixel_in),
        .room      (lut_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out)
    );

endmodule

### rtl/core/plsg_div.sv
// Restoring divider for 8-bit operands, one quotient bit per cycle.
module plsg_div
    import plsg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  level_t   num,
    input  level_t   den,
    output logic     busy,
    output div_res_t res
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    level_t               quo_reg;
    level_t               rem_reg;
    level_t               den_reg;
    logic [LEVEL_W:0]     shifted;
    logic                 fits;

    assign shifted = {rem_reg, quo_reg[LEVEL_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[LEVEL_W-2:0], fits};
            if (fits)
            begin
                rem_reg <= level_t'(shifted - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= shifted[LEVEL_W-1:0];
            end
        end
    end

    assign busy    = cnt_reg != '0;
    assign res.quo = quo_reg;
    assign res.rem = rem_reg;

endmodule

### rtl/core/plsg_ramp.sv
// Incremental line generator giving floor(rise * offset / span) one offset per step.
module plsg_ramp
    import plsg_pkg::*;
(
    input  logic     clk,
    input  logic     clear,
    input  logic     advance,
    input  div_res_t step,
    input  level_t   span,
    output level_t   level
);

    level_t           q_reg;
    level_t           r_reg;
    logic [LEVEL_W:0] sum;
    logic             carry;

    assign sum   = {1'b0, r_reg} + {1'b0, step.rem};
    assign carry = sum >= {1'b0, span};

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            q_reg <= '0;
            r_reg <= '0;
        end
        else if (advance)
        begin
            q_reg <= q_reg + step.quo + level_t'(carry);
            if (carry)
            begin
                r_reg <= level_t'(sum - {1'b0, span});
            end
            else
            begin
                r_reg <= sum[LEVEL_W-1:0];
            end
        end
    end

    assign level = q_reg;

endmodule

### rtl/core/plsg_lut.sv
// Mapping table memory with its registered read and the output queue.
module plsg_lut
    import plsg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  lut_wr_t wr,
    input  logic    rd_en,
    input  level_t  rd_addr,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output level_t  pixel_out
);

    level_t               mem [LUT_DEPTH];
    level_t               rdata_reg;
    logic                 rd_valid_reg;
    level_t               fifo_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wptr_reg;
    logic [OUT_PTR_W-1:0] rptr_reg;
    logic [OUT_CNT_W-1:0] count_reg;
    logic [OUT_CNT_W-1:0] count_next;
    logic [OUT_CNT_W:0]   occupancy;
    logic                 pop;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign pop       = out_valid && out_ready;
    assign occupancy = {1'b0, count_reg} + (OUT_CNT_W + 1)'(rd_valid_reg);
    assign room      = occupancy < (OUT_CNT_W + 1)'(OUT_DEPTH);

    always_comb
    begin
        count_next = count_reg;
        if (rd_valid_reg && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!rd_valid_reg && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            count_reg    <= '0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
            count_reg    <= count_next;
            if (rd_valid_reg)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            fifo_reg[wptr_reg] <= rdata_reg;
        end
    end

    assign out_valid = count_reg != '0;
    assign pixel_out = fifo_reg[rptr_reg];

endmodule

### rtl/core/plsg_checker.sv
// Port-level checker of the piecewise-linear gray stretch unit and its bind.
module plsg_checker
    import plsg_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_we,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [LEVEL_W-1:0]   pixel_out
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out))
        else $error("stalled output beat was not held");

    a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_ready)
        else $error("input taken while the table is being rebuilt");

    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("output beat appeared without an input beat two cycles before");

endmodule

bind piecewise_linear_gray_stretch_unit plsg_checker u_plsg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out)
);
